@@ sv/atpc_pkg.sv @@
package atpc_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int EXP_W        = 14;
	localparam int RAMP_W       = 7;
	localparam int LFSR_W       = 23;
	localparam int LFSR_TAP_HI  = 22;
	localparam int LFSR_TAP_LO  = 17;
	localparam int ERR_W        = 20;
	localparam int LIMIT_W      = 8;
	localparam int CFG_DATA_W   = 23;
	localparam int CFG_INDEX_W  = 2;
	localparam int PN_STEPS_DEF = 14;

	localparam logic [LFSR_W-1:0]  PN_SEED_RESET   = 23'h7FAE00;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 8'd4;
	localparam logic               TEST_MODE_RESET = 1'b1;
	localparam logic [ERR_W-1:0]   ERR_MAX         = '1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEST_MODE   = 2'd0,
		REG_PN_SEED     = 2'd1,
		REG_RESYNC_LIMIT = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic                test_mode;
		logic [LFSR_W-1:0]   pn_seed;
		logic [LIMIT_W-1:0]  resync_error_limit;
	} atpc_cfg_t;

	typedef struct packed {
		logic               mismatch;
		logic [EXP_W-1:0]   expected_value;
		logic [ERR_W-1:0]   block_errors;
		logic               resynced;
		logic               channels_differ;
	} atpc_result_t;

	// Shift the LFSR a given number of times, at most 23; feedback enters at bit 0.
	function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v,
			input int steps);
		logic [LFSR_W-1:0] r;
		r = v;
		for (int k = 0; k < LFSR_W; k++) begin
			if (k < steps) begin
				r = {r[LFSR_W-2:0], r[LFSR_TAP_HI] ^ r[LFSR_TAP_LO]};
			end
		end
		return r;
	endfunction

endpackage

@@ sv/atpc_if.sv @@
interface atpc_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [atpc_pkg::SAMPLE_W-1:0]  sample_a;
	logic signed [atpc_pkg::SAMPLE_W-1:0]  sample_b;
	logic                                  block_start;
	logic                                  restart;

	modport source (output valid, sample_a, sample_b, block_start, restart, input ready);
	modport sink (input valid, sample_a, sample_b, block_start, restart, output ready);
endinterface

interface atpc_out_if;
	logic                              valid;
	logic                              ready;
	logic                              mismatch;
	logic [atpc_pkg::EXP_W-1:0]        expected_value;
	logic [atpc_pkg::ERR_W-1:0]        block_errors;
	logic                              resynced;
	logic                              channels_differ;

	modport source (output valid, mismatch, expected_value, block_errors, resynced,
		channels_differ, input ready);
	modport sink (input valid, mismatch, expected_value, block_errors, resynced,
		channels_differ, output ready);
endinterface

@@ sv/atpc_cfg_regs.sv @@
module atpc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [atpc_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [atpc_pkg::CFG_DATA_W-1:0]      wr_data,
	output atpc_pkg::atpc_cfg_t                  cfg
);

	atpc_pkg::atpc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.test_mode          <= atpc_pkg::TEST_MODE_RESET;
			cfg_q.pn_seed            <= atpc_pkg::PN_SEED_RESET;
			cfg_q.resync_error_limit <= atpc_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			// unused index: drop the write
			unique case (atpc_pkg::reg_index_t'(wr_index))
				atpc_pkg::REG_TEST_MODE: begin
					cfg_q.test_mode <= wr_data[0];
				end
				atpc_pkg::REG_PN_SEED: begin
					cfg_q.pn_seed <= wr_data[atpc_pkg::LFSR_W-1:0];
				end
				atpc_pkg::REG_RESYNC_LIMIT: begin
					cfg_q.resync_error_limit <= wr_data[atpc_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/atpc_check.sv @@
module atpc_check #(
	parameter int PN_STEPS = atpc_pkg::PN_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  atpc_pkg::atpc_cfg_t                   cfg,
	input  logic                                  advance,
	input  logic signed [atpc_pkg::SAMPLE_W-1:0]  sample_a,
	input  logic signed [atpc_pkg::SAMPLE_W-1:0]  sample_b,
	input  logic                                  block_start,
	input  logic                                  restart,
	output atpc_pkg::atpc_result_t                result
);

	localparam int LW = atpc_pkg::LFSR_W;
	localparam int RW = atpc_pkg::RAMP_W;
	localparam int EW = atpc_pkg::ERR_W;
	localparam int XW = atpc_pkg::EXP_W;
	localparam int SW = atpc_pkg::SAMPLE_W;

	logic [LW-1:0] checker_q;
	logic [EW-1:0] err_q;

	logic [LW-1:0] cv_base;
	logic [EW-1:0] err_base;
	logic [EW-1:0] err_next;
	logic [LW-1:0] cur;
	logic [LW-1:0] cv_next;
	logic [XW-1:0] expv;
	logic [SW-1:0] ua;
	logic [SW-1:0] ub;
	logic [RW-1:0] ramp_inc;
	logic          pn;
	logic          differ;
	logic          mis;
	logic          do_resync;

	always_comb begin
		pn       = cfg.test_mode;
		ua       = SW'(sample_a);
		ub       = SW'(sample_b);
		differ   = (ua != ub);
		err_base = block_start ? '0 : err_q;
		if (restart) begin
			cv_base = pn ? cfg.pn_seed : '0;
		end else begin
			cv_base = checker_q;
		end

		if (pn) begin
			expv = cv_base[LW-1 -: XW];
			mis  = (ua[XW-1:0] != expv) || (ub[XW-1:0] != expv);
		end else begin
			expv = XW'(cv_base[RW-1:0]);
			mis  = (ua != SW'(cv_base[RW-1:0])) || (ub != SW'(cv_base[RW-1:0]));
		end

		do_resync = mis && !differ &&
			(err_base < EW'(cfg.resync_error_limit));

		if (do_resync) begin
			cur = LW'(ua[RW-1:0]);
		end else if (pn) begin
			cur = cv_base;
		end else begin
			cur = LW'(cv_base[RW-1:0]);
		end

		ramp_inc = cur[RW-1:0] + RW'(1);
		cv_next  = pn ? atpc_pkg::lfsr_advance(cur, PN_STEPS) : LW'(ramp_inc);

		if (mis && (err_base != atpc_pkg::ERR_MAX)) begin
			err_next = err_base + EW'(1);
		end else begin
			err_next = err_base;
		end

		result.mismatch        = mis;
		result.expected_value  = expv;
		result.block_errors    = err_next;
		result.resynced        = do_resync;
		result.channels_differ = differ;
	end

	// Advance the pattern state once per word handed to the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checker_q <= atpc_pkg::PN_SEED_RESET;
			err_q     <= '0;
		end else if (advance) begin
			checker_q <= cv_next;
			err_q     <= err_next;
		end
	end

endmodule

@@ sv/adc_test_pattern_checker_unit.sv @@
// An accepted word is checked in the input register; its result loads once the result register is free.
// Throughput: one word per cycle while the result side is ready; input and result registers decouple the sides.
// The whole check, including the PN_STEPS-shift LFSR advance (14 by default), sits between those two registers.
// Reset (arst_n low, asynchronous): registers to defaults (PN mode, seed 0x7FAE00,
// resync limit 4), pattern state to the seed, error count to zero, both stages empty.
module adc_test_pattern_checker_unit #(
	parameter int PN_STEPS = atpc_pkg::PN_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [atpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [atpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	atpc_in_if.sink                           samples,
	atpc_out_if.source                        results
);

	atpc_pkg::atpc_cfg_t    cfg;
	atpc_pkg::atpc_result_t res_comb;
	atpc_pkg::atpc_result_t res_s2;

	// Input stage
	logic                                 valid_s1;
	logic signed [atpc_pkg::SAMPLE_W-1:0] sample_a_s1;
	logic signed [atpc_pkg::SAMPLE_W-1:0] sample_b_s1;
	logic                                 block_start_s1;
	logic                                 restart_s1;

	// Result stage
	logic valid_s2;

	logic advance;
	logic take_in;

	// Move the input word on when the result register is empty or being drained.
	assign advance       = valid_s1 && (!valid_s2 || results.ready);
	assign samples.ready = !valid_s1 || advance;
	assign take_in       = samples.valid && samples.ready;

	atpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	atpc_check #(
		.PN_STEPS (PN_STEPS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.advance     (advance),
		.sample_a    (sample_a_s1),
		.sample_b    (sample_b_s1),
		.block_start (block_start_s1),
		.restart     (restart_s1),
		.result      (res_comb)
	);

	// Hold the input word until the check consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_a_s1    <= samples.sample_a;
			sample_b_s1    <= samples.sample_b;
			block_start_s1 <= samples.block_start;
			restart_s1     <= samples.restart;
		end
	end

	// Result register: load on advance, drop once taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign results.valid           = valid_s2;
	assign results.mismatch        = res_s2.mismatch;
	assign results.expected_value  = res_s2.expected_value;
	assign results.block_errors    = res_s2.block_errors;
	assign results.resynced        = res_s2.resynced;
	assign results.channels_differ = res_s2.channels_differ;

`ifndef ASSERT_OFF
	// A resync only follows a mismatch on equal channels.
	a_resync_cause: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (!results.resynced ||
			(results.mismatch && !results.channels_differ)))
		else $error("resync without a mismatch on equal channels");

	// A mismatch always leaves a nonzero error count.
	a_mismatch_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.mismatch) |-> (results.block_errors != '0))
		else $error("mismatch reported with zero block errors");

	// The input side never stalls while the result register can drain.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s2 || results.ready) |-> samples.ready)
		else $error("input stalled with a free result stage");

	// Every word moved from the input stage shows up as a result next cycle.
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced word lost before the result register");
`endif

endmodule

@@ bench/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W     = atpc_pkg::SAMPLE_W;
	localparam int EXP_W        = atpc_pkg::EXP_W;
	localparam int RAMP_W       = atpc_pkg::RAMP_W;
	localparam int LFSR_W       = atpc_pkg::LFSR_W;
	localparam int LFSR_TAP_HI  = atpc_pkg::LFSR_TAP_HI;
	localparam int LFSR_TAP_LO  = atpc_pkg::LFSR_TAP_LO;
	localparam int ERR_W        = atpc_pkg::ERR_W;
	localparam int LIMIT_W      = atpc_pkg::LIMIT_W;
	localparam int CFG_DATA_W   = atpc_pkg::CFG_DATA_W;
	localparam int CFG_INDEX_W  = atpc_pkg::CFG_INDEX_W;

	// Two register stages between input and output; the spare drain cycles cover them.
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 200;
	localparam int PN_SHIFTS    = atpc_pkg::PN_STEPS_DEF;
	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 125;
	localparam int PRINT_CAP    = 50;

	// Index with no register behind it; the block must ignore writes to it.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam atpc_pkg::atpc_result_t NO_RESULT = '0;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_WORD,
		ROW_TRACK
	} row_kind_t;

	// One line of the directed table: a register write, a fixed word, or a word
	// whose low 14 bits follow the expected pattern (upper bits taken from the row).
	typedef struct {
		row_kind_t               kind;
		logic [CFG_INDEX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0]   data;
		logic [SAMPLE_W-1:0]     a;
		logic [SAMPLE_W-1:0]     b;
		logic                    bs;
		logic                    rs;
		bit                      typed;
		atpc_pkg::atpc_result_t  want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	atpc_in_if  samples_if ();
	atpc_out_if results_if ();

	adc_test_pattern_checker_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_if),
		.results   (results_if)
	);

	// Pattern checker prediction: register copies and state.
	logic                pred_mode;
	logic [LFSR_W-1:0]   pred_seed;
	logic [LIMIT_W-1:0]  pred_limit;
	logic [LFSR_W-1:0]   pred_value;
	logic [ERR_W-1:0]    pred_errors;

	atpc_pkg::atpc_result_t pending_results[$];
	plan_row_t              directed_plan[$];
	int                     fault_count;
	bit                     hold_off;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(2_000_000);
		$display("adc_test_pattern_checker_unit test failed");
		$finish;
	end

	task automatic report_error(input string msg);
		// Keep the log short on a broken build; every fault is still counted.
		if (fault_count < PRINT_CAP) begin
			$display("ERROR %0t: %s", $realtime, msg);
		end
		fault_count++;
	endtask

	function automatic logic [LFSR_W-1:0] pn_advance(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v;
		repeat (PN_SHIFTS) s = {s[LFSR_W-2:0], s[LFSR_TAP_HI] ^ s[LFSR_TAP_LO]};
		return s;
	endfunction

	// Value the checker compares the next word against, given its restart flag.
	function automatic logic [EXP_W-1:0] pattern_expected(input logic rs);
		logic [LFSR_W-1:0] v;
		v = rs ? (pred_mode ? pred_seed : '0) : pred_value;
		return pred_mode ? v[LFSR_W-1 -: EXP_W] : {{(EXP_W-RAMP_W){1'b0}}, v[RAMP_W-1:0]};
	endfunction

	// Check one sample pair and advance the pattern state.
	function automatic atpc_pkg::atpc_result_t check_pattern(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b, input logic bs, input logic rs);
		atpc_pkg::atpc_result_t r;
		logic [LFSR_W-1:0] cur;
		logic [EXP_W-1:0]  expv;
		logic              mis;
		logic              differ;
		logic              rsy;
		differ = (a != b);
		rsy = 1'b0;
		if (bs) begin
			pred_errors = '0;
		end
		if (rs) begin
			pred_value = pred_mode ? pred_seed : '0;
		end
		if (pred_mode) begin
			cur = pred_value;
			expv = cur[LFSR_W-1 -: EXP_W];
			mis = (a[EXP_W-1:0] != expv) || (b[EXP_W-1:0] != expv);
		end else begin
			// Ramp uses only the low 7 bits and compares the whole sample.
			cur = {{(LFSR_W-RAMP_W){1'b0}}, pred_value[RAMP_W-1:0]};
			expv = {{(EXP_W-RAMP_W){1'b0}}, pred_value[RAMP_W-1:0]};
			mis = (a != {{(SAMPLE_W-RAMP_W){1'b0}}, pred_value[RAMP_W-1:0]})
				|| (b != {{(SAMPLE_W-RAMP_W){1'b0}}, pred_value[RAMP_W-1:0]});
		end
		if (mis) begin
			if (pred_errors < pred_limit && !differ) begin
				cur = {{(LFSR_W-RAMP_W){1'b0}}, a[RAMP_W-1:0]};
				rsy = 1'b1;
			end
			if (pred_errors != atpc_pkg::ERR_MAX) begin
				pred_errors++;
			end
		end
		if (pred_mode) begin
			pred_value = pn_advance(cur);
		end else begin
			pred_value = {{(LFSR_W-RAMP_W){1'b0}}, cur[RAMP_W-1:0] + 7'd1};
		end
		r.mismatch = mis;
		r.expected_value = expv;
		r.block_errors = pred_errors;
		r.resynced = rsy;
		r.channels_differ = differ;
		return r;
	endfunction

	function automatic atpc_pkg::atpc_result_t mk_result(input logic mis,
			input logic [EXP_W-1:0] expv, input logic [ERR_W-1:0] errs, input logic rsy,
			input logic diff);
		atpc_pkg::atpc_result_t r;
		r.mismatch = mis;
		r.expected_value = expv;
		r.block_errors = errs;
		r.resynced = rsy;
		r.channels_differ = diff;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		r.a = '0;
		r.b = '0;
		r.bs = 1'b0;
		r.rs = 1'b0;
		r.typed = 1'b0;
		r.want = NO_RESULT;
		return r;
	endfunction

	function automatic plan_row_t word_row(input row_kind_t kind, input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b, input logic bs, input logic rs, input bit typed,
			input atpc_pkg::atpc_result_t want);
		plan_row_t r;
		r.kind = kind;
		r.idx = '0;
		r.data = '0;
		r.a = a;
		r.b = b;
		r.bs = bs;
		r.rs = rs;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	// Idle draw shared by both sides: mostly a random gap, now and then a calm run with no gap.
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// Offer one word after an idle gap; predict it at the edge it is taken.
	task automatic send_word(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
			input logic bs, input logic rs, input int gap, input bit typed,
			input atpc_pkg::atpc_result_t want);
		atpc_pkg::atpc_result_t predicted;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid       <= 1'b1;
		samples_if.sample_a    <= a;
		samples_if.sample_b    <= b;
		samples_if.block_start <= bs;
		samples_if.restart     <= rs;
		do @(posedge clk); while (!samples_if.ready);
		predicted = check_pattern(a, b, bs, rs);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Drop valid and wait until every predicted word has come out.
	task automatic quiesce();
		samples_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write, with wr_en dropped again before the task returns so back-to-back writes stay apart.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			atpc_pkg::REG_TEST_MODE: pred_mode = data[0];
			atpc_pkg::REG_PN_SEED: pred_seed = data[LFSR_W-1:0];
			atpc_pkg::REG_RESYNC_LIMIT: pred_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Result side: stall at random, and once hold off long enough to back up the input.
	initial begin : result_sink
		int stall;
		int calm;
		results_if.ready = 1'b0;
		calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			stall = draw_idle(calm);
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			do @(posedge clk); while (!results_if.valid);
		end
	end

	// Compare every word taken at the output with the oldest prediction.
	always @(posedge clk) begin : result_monitor
		atpc_pkg::atpc_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_results.size() == 0) begin
				report_error("result word with no prediction waiting");
			end else begin
				want = pending_results.pop_front();
				if (results_if.mismatch !== want.mismatch)
					report_error($sformatf("mismatch got %b want %b",
						results_if.mismatch, want.mismatch));
				if (results_if.expected_value !== want.expected_value)
					report_error($sformatf("expected_value got %h want %h",
						results_if.expected_value, want.expected_value));
				if (results_if.block_errors !== want.block_errors)
					report_error($sformatf("block_errors got %0d want %0d",
						results_if.block_errors, want.block_errors));
				if (results_if.resynced !== want.resynced)
					report_error($sformatf("resynced got %b want %b",
						results_if.resynced, want.resynced));
				if (results_if.channels_differ !== want.channels_differ)
					report_error($sformatf("channels_differ got %b want %b",
						results_if.channels_differ, want.channels_differ));
			end
		end
	end

	initial begin : stimulus
		int               i;
		int               p;
		int               gap;
		int               pick;
		int               send_calm;
		int               pressure_left;
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic             bs;
		logic             rs;
		logic [EXP_W-1:0] expv;
		logic [CFG_DATA_W-1:0] seed_w;
		plan_row_t        row;

		// Every input known from time zero.
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_if.valid = 1'b0;
		samples_if.sample_a = '0;
		samples_if.sample_b = '0;
		samples_if.block_start = 1'b0;
		samples_if.restart = 1'b0;
		fault_count = 0;
		hold_off = 1'b0;
		send_calm = 0;
		pressure_left = 0;

		// Predictor copy of the reset state: PN mode, default seed and limit.
		pred_mode = atpc_pkg::TEST_MODE_RESET;
		pred_seed = atpc_pkg::PN_SEED_RESET;
		pred_limit = atpc_pkg::LIMIT_RESET;
		pred_value = atpc_pkg::PN_SEED_RESET;
		pred_errors = '0;

		// Directed table. Typed rows carry their answer; the rest go to the predictor.
		// Right after reset the seed's top 14 bits are the first PN value.
		directed_plan.push_back(word_row(ROW_WORD, 16'h3FD7, 16'h3FD7, 1'b1, 1'b1, 1'b1,
			mk_result(1'b0, 14'h3FD7, 20'd0, 1'b0, 1'b0)));
		// PN compares the low 14 bits only: differing upper bits still match.
		directed_plan.push_back(word_row(ROW_TRACK, 16'hC000, 16'h4000, 1'b0, 1'b0, 1'b0,
			NO_RESULT));
		// Largest and smallest samples, channels apart: counted, no resync.
		directed_plan.push_back(word_row(ROW_WORD, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b0,
			NO_RESULT));
		// Equal channels off the pattern: resync from channel A in PN mode.
		directed_plan.push_back(word_row(ROW_WORD, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0,
			NO_RESULT));
		directed_plan.push_back(word_row(ROW_TRACK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_RESULT));
		directed_plan.push_back(word_row(ROW_WORD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0,
			NO_RESULT));
		// Write to an index with no register: nothing may change.
		directed_plan.push_back(cfg_row(REG_UNUSED, '1));
		directed_plan.push_back(word_row(ROW_TRACK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_RESULT));
		// All-ones seed.
		directed_plan.push_back(cfg_row(atpc_pkg::REG_PN_SEED, 23'h7FFFFF));
		directed_plan.push_back(word_row(ROW_WORD, 16'h3FFF, 16'h3FFF, 1'b1, 1'b1, 1'b1,
			mk_result(1'b0, 14'h3FFF, 20'd0, 1'b0, 1'b0)));
		directed_plan.push_back(word_row(ROW_TRACK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_RESULT));
		// Switch to ramp without restart: the wide LFSR value keeps only its low 7 bits.
		directed_plan.push_back(cfg_row(atpc_pkg::REG_TEST_MODE, 23'd0));
		directed_plan.push_back(word_row(ROW_TRACK, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_RESULT));
		directed_plan.push_back(word_row(ROW_WORD, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1,
			mk_result(1'b0, 14'd0, 20'd0, 1'b0, 1'b0)));
		directed_plan.push_back(word_row(ROW_WORD, 16'h0001, 16'h0001, 1'b0, 1'b0, 1'b1,
			mk_result(1'b0, 14'd1, 20'd0, 1'b0, 1'b0)));
		// Negative sample never matches the ramp; resync to 127 then wrap to 0.
		directed_plan.push_back(word_row(ROW_WORD, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1,
			mk_result(1'b1, 14'd2, 20'd1, 1'b1, 1'b0)));
		directed_plan.push_back(word_row(ROW_WORD, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1,
			mk_result(1'b0, 14'd0, 20'd1, 1'b0, 1'b0)));
		// Only channel B wrong: counted, channels differ so no resync.
		directed_plan.push_back(word_row(ROW_WORD, 16'h0001, 16'h0081, 1'b0, 1'b0, 1'b1,
			mk_result(1'b1, 14'd1, 20'd2, 1'b0, 1'b1)));
		// Limit zero: resync never allowed.
		directed_plan.push_back(cfg_row(atpc_pkg::REG_RESYNC_LIMIT, 23'd0));
		directed_plan.push_back(word_row(ROW_WORD, 16'h1234, 16'h1234, 1'b0, 1'b0, 1'b1,
			mk_result(1'b1, 14'd2, 20'd3, 1'b0, 1'b0)));
		// Limit at its top: resync to 0x10, then 0x11 matches.
		directed_plan.push_back(cfg_row(atpc_pkg::REG_RESYNC_LIMIT, 23'd255));
		directed_plan.push_back(word_row(ROW_WORD, 16'h0010, 16'h0010, 1'b0, 1'b0, 1'b1,
			mk_result(1'b1, 14'd3, 20'd4, 1'b1, 1'b0)));
		directed_plan.push_back(word_row(ROW_WORD, 16'h0011, 16'h0011, 1'b0, 1'b0, 1'b1,
			mk_result(1'b0, 14'd17, 20'd4, 1'b0, 1'b0)));
		// Zero seed locks the LFSR at zero.
		directed_plan.push_back(cfg_row(atpc_pkg::REG_TEST_MODE, 23'd1));
		directed_plan.push_back(cfg_row(atpc_pkg::REG_PN_SEED, 23'd0));
		directed_plan.push_back(word_row(ROW_WORD, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1,
			mk_result(1'b0, 14'd0, 20'd0, 1'b0, 1'b0)));
		directed_plan.push_back(word_row(ROW_WORD, 16'h8000, 16'h4000, 1'b0, 1'b0, 1'b1,
			mk_result(1'b0, 14'd0, 20'd0, 1'b0, 1'b1)));
		// Back to the reset settings.
		directed_plan.push_back(cfg_row(atpc_pkg::REG_PN_SEED, atpc_pkg::PN_SEED_RESET));
		directed_plan.push_back(cfg_row(atpc_pkg::REG_RESYNC_LIMIT,
			CFG_DATA_W'(atpc_pkg::LIMIT_RESET)));
		directed_plan.push_back(word_row(ROW_WORD, 16'h3FD7, 16'h3FD7, 1'b1, 1'b1, 1'b1,
			mk_result(1'b0, 14'h3FD7, 20'd0, 1'b0, 1'b0)));

		// Reset once, then release on a clock edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		foreach (directed_plan[k]) begin
			row = directed_plan[k];
			if (row.kind == ROW_CFG) begin
				quiesce();
				write_reg(row.idx, row.data);
			end else begin
				a = row.a;
				b = row.b;
				if (row.kind == ROW_TRACK) begin
					expv = pattern_expected(row.rs);
					a[EXP_W-1:0] = expv;
					b[EXP_W-1:0] = expv;
				end
				send_word(a, b, row.bs, row.rs, draw_idle(send_calm), row.typed, row.want);
			end
		end

		// Random phases. Each one reprograms all registers; some hit the extremes.
		for (p = 0; p < PHASES; p++) begin
			quiesce();
			write_reg(atpc_pkg::REG_TEST_MODE, CFG_DATA_W'(p[0]));
			if (p == 2) begin
				seed_w = 23'h7FFFFF;
			end else if (p == 4) begin
				seed_w = '0;
			end else begin
				seed_w = CFG_DATA_W'($urandom);
			end
			write_reg(atpc_pkg::REG_PN_SEED, seed_w);
			if (p == 3) begin
				seed_w = '0;
			end else if (p == 5) begin
				seed_w = 23'd255;
			end else begin
				seed_w = CFG_DATA_W'($urandom_range(0, 255));
			end
			write_reg(atpc_pkg::REG_RESYNC_LIMIT, seed_w);
			for (i = 0; i < PHASE_WORDS; i++) begin
				bs = (i == 0) || ($urandom_range(0, 31) == 0);
				rs = (i == 0) || ($urandom_range(0, 39) == 0);
				// Mostly words on the pattern so the checker stays locked; the rest
				// are equal-channel errors, single-channel errors and noise.
				expv = pattern_expected(rs);
				a = {{(SAMPLE_W-EXP_W){1'b0}}, expv};
				b = a;
				if (pred_mode) begin
					a[SAMPLE_W-1:EXP_W] = (SAMPLE_W-EXP_W)'($urandom);
					b[SAMPLE_W-1:EXP_W] = $urandom_range(0, 1) ? a[SAMPLE_W-1:EXP_W] :
						(SAMPLE_W-EXP_W)'($urandom);
				end
				pick = $urandom_range(0, 9);
				case (pick)
					7: begin
						a = SAMPLE_W'($urandom);
						b = a;
					end
					8: b[$urandom_range(0, SAMPLE_W-1)] ^= 1'b1;
					9: begin
						a = SAMPLE_W'($urandom);
						b = SAMPLE_W'($urandom);
					end
					default: ;
				endcase
				// Once: stop the result side for a long stretch and keep offering words.
				if (p == 1 && i == 60) begin
					hold_off = 1'b1;
					pressure_left = 40;
				end
				if (pressure_left > 0) begin
					pressure_left--;
					gap = 0;
				end else begin
					gap = draw_idle(send_calm);
				end
				send_word(a, b, bs, rs, gap, 1'b0, NO_RESULT);
			end
		end

		quiesce();
		if (fault_count == 0) begin
			$display("adc_test_pattern_checker_unit test passed");
		end else begin
			$display("adc_test_pattern_checker_unit test failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/atpc_pkg.sv
sv/atpc_if.sv
sv/atpc_cfg_regs.sv
sv/atpc_check.sv
sv/adc_test_pattern_checker_unit.sv
bench/tb.sv
